>>> design/vsfa_pkg.sv
// Types, codes and record helpers for the video slice frame assembler.
package vsfa_pkg;

    localparam int GRP_DEPTH = 4;
    localparam int PTR_W     = 2;
    localparam int CNT_W     = 3;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_SEQ   = 4'd1,
        PH_LEN0  = 4'd2,
        PH_LEN1  = 4'd3,
        PH_LEN2  = 4'd4,
        PH_LEN3  = 4'd5,
        PH_POS0  = 4'd6,
        PH_POS1  = 4'd7,
        PH_POS2  = 4'd8,
        PH_POS3  = 4'd9,
        PH_PIC   = 4'd10,
        PH_SLICE = 4'd11,
        PH_FRAME = 4'd12
    } t_phase;

    typedef enum logic [2:0] {
        K_WRITE   = 3'd0,
        K_ENTRY   = 3'd1,
        K_DONE    = 3'd2,
        K_RESTART = 3'd3,
        K_ERROR   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        PT_SLICE      = 2'd0,
        PT_WHOLE      = 2'd1,
        PT_LAST_SLICE = 2'd2,
        PT_IN_PACKET  = 2'd3
    } t_ptype;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  idx;
        logic [29:0] off;
        logic [7:0]  val;
    } t_rec;

    // records caused by one byte, up to three
    typedef struct packed {
        logic [1:0]     n;
        t_rec [2:0]     rec;
    } t_group;

    function automatic t_rec mk_rec(t_kind kind, logic [7:0] idx, logic [29:0] off,
                                    logic [7:0] val);
        t_rec r;
        r.kind = kind;
        r.idx  = idx;
        r.off  = off;
        r.val  = val;
        return r;
    endfunction

endpackage

>>> design/video_slice_frame_assembler_core.sv
// Video slice frame assembler: packet byte parser, slice frame state and record queue.
// A byte accepted into the input register is parsed there; its record group is written
// into the queue, and its first record is shown from the queue head after that write.
// Throughput: one byte per cycle while the queue has room; a byte's records are shown one
// at a time, and input stalls only when the four-entry record-group queue is full.
// Reset: synchronous, active low; clears parse state, frame state and the queue.
module video_slice_frame_assembler_core
    import vsfa_pkg::*;
#(
    parameter int PACKET_LENGTH_MAX = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_of_packet,
    input  logic [15:0] i_packet_length,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_slice_index,
    output logic [29:0] o_offset,
    output logic [7:0]  o_data_value,
    output logic        o_last_of_run
);

    localparam logic [15:0] PLEN_MAX = PACKET_LENGTH_MAX[15:0];

    // input register
    logic        r_in_v;
    logic [7:0]  r_in_byte;
    logic        r_in_first;
    logic [15:0] r_in_plen;

    // parse and frame state
    t_phase      r_phase, n_phase;
    t_ptype      r_type, n_type;
    logic [5:0]  r_low, n_low;
    logic [7:0]  r_seq, n_seq;
    logic [29:0] r_accum, n_accum;
    logic [29:0] r_fl, n_fl;
    logic [29:0] r_spos, n_spos;
    logic [7:0]  r_pic, n_pic;
    logic        r_fopen, n_fopen;
    logic [7:0]  r_cap, n_cap;
    logic [7:0]  r_ss, n_ss;
    logic [29:0] r_wo, n_wo;
    logic [15:0] r_bl, n_bl;
    logic [29:0] r_pl, n_pl;

    t_group      n_grp;

    // working values
    logic [15:0] plen;
    logic        ended;
    logic [14:0] nn15;
    logic        num_done;
    logic [29:0] num_val;
    logic        do_direct;
    logic [29:0] dlen;
    logic        do_slice;
    logic [15:0] slen;
    logic [30:0] wsum;

    // record-group queue
    t_group            r_fifo [GRP_DEPTH];
    logic [PTR_W-1:0]  r_wp, r_rp;
    logic [CNT_W-1:0]  r_cnt;
    logic [1:0]        r_sub;
    t_group            head;
    t_rec              head_rec;
    logic              adv, push, pop, take, out_last;

    assign adv     = r_in_v && (r_cnt != CNT_W'(GRP_DEPTH));
    assign o_stall = r_in_v && !adv;
    assign push    = adv && (n_grp.n != 2'd0);

    assign head     = r_fifo[r_rp];
    assign head_rec = head.rec[r_sub];
    assign o_valid  = (r_cnt != '0);
    assign out_last = (r_sub == head.n - 2'd1);
    assign take     = o_valid && !i_stall;
    assign pop      = take && out_last;

    assign o_kind        = head_rec.kind;
    assign o_slice_index = head_rec.idx;
    assign o_offset      = head_rec.off;
    assign o_data_value  = head_rec.val;
    assign o_last_of_run = out_last;

    always_comb begin
        n_phase   = r_phase;
        n_type    = r_type;
        n_low     = r_low;
        n_seq     = r_seq;
        n_accum   = r_accum;
        n_fl      = r_fl;
        n_spos    = r_spos;
        n_pic     = r_pic;
        n_fopen   = r_fopen;
        n_cap     = r_cap;
        n_ss      = r_ss;
        n_wo      = r_wo;
        n_bl      = r_bl;
        n_pl      = r_pl;
        n_grp     = '0;
        plen      = r_in_plen;
        ended     = 1'b0;
        nn15      = {r_accum[6:0], r_in_byte};
        num_done  = 1'b0;
        num_val   = '0;
        do_direct = 1'b0;
        dlen      = '0;
        do_slice  = 1'b0;
        slen      = '0;
        wsum      = '0;

        if (r_in_first) begin
            if (plen > PLEN_MAX) plen = PLEN_MAX;
            if (plen == 16'd0) plen = 16'd1;
            n_bl    = plen - 16'd1;
            n_type  = t_ptype'(r_in_byte[7:6]);
            n_low   = r_in_byte[5:0];
            n_phase = (n_type == PT_IN_PACKET) ? PH_LEN0 : PH_SEQ;
            if (n_bl == 16'd0) begin
                n_phase = PH_IDLE;
                n_grp.rec[n_grp.n] = mk_rec(K_ERROR, 8'd0, 30'd0, 8'd0);
                n_grp.n = n_grp.n + 2'd1;
            end
        end else if (r_bl == 16'd0) begin
            n_phase = PH_IDLE;
        end else begin
            n_bl  = r_bl - 16'd1;
            ended = (n_bl == 16'd0);
            unique case (r_phase)
                PH_SEQ: begin
                    n_seq = r_in_byte;
                    if (r_type == PT_WHOLE) begin
                        do_direct = 1'b1;
                        dlen      = {14'd0, n_bl};
                    end else begin
                        n_phase = PH_LEN0;
                    end
                end
                PH_LEN0, PH_POS0: begin
                    n_accum = {22'd0, r_in_byte};
                    n_phase = t_phase'(r_phase + 4'd1);
                end
                PH_LEN1, PH_POS1: begin
                    // short form: bit 14 set gives a 14-bit value
                    if (nn15[14]) begin
                        num_done = 1'b1;
                        num_val  = {16'd0, nn15[13:0]};
                    end else begin
                        n_accum = {15'd0, nn15};
                        n_phase = t_phase'(r_phase + 4'd1);
                    end
                end
                PH_LEN2, PH_POS2: begin
                    n_accum = {r_accum[21:0], r_in_byte};
                    n_phase = t_phase'(r_phase + 4'd1);
                end
                PH_LEN3, PH_POS3: begin
                    n_accum  = {r_accum[21:0], r_in_byte};
                    num_done = 1'b1;
                    num_val  = n_accum;
                end
                PH_PIC: begin
                    if (r_type == PT_IN_PACKET) begin
                        do_direct = 1'b1;
                        dlen      = r_pl;
                    end else begin
                        do_slice = 1'b1;
                    end
                end
                PH_SLICE: begin
                    n_grp.rec[n_grp.n] = mk_rec(K_WRITE, 8'd0, r_wo, r_in_byte);
                    n_grp.n = n_grp.n + 2'd1;
                    n_wo = r_wo + 30'd1;
                    n_pl = r_pl - 30'd1;
                    if (n_pl == 30'd0) begin
                        n_phase = PH_IDLE;
                        if (r_type == PT_LAST_SLICE || n_wo == r_fl) begin
                            n_grp.rec[n_grp.n] = mk_rec(K_DONE, r_ss, n_wo, 8'd0);
                            n_grp.n = n_grp.n + 2'd1;
                        end
                    end
                end
                PH_FRAME: begin
                    n_grp.rec[n_grp.n] = mk_rec(K_WRITE, 8'd0, r_accum, r_in_byte);
                    n_grp.n = n_grp.n + 2'd1;
                    n_accum = r_accum + 30'd1;
                    n_pl    = r_pl - 30'd1;
                    if (n_pl == 30'd0) begin
                        n_phase = PH_IDLE;
                        n_grp.rec[n_grp.n] = mk_rec(K_DONE, 8'd1, n_accum, 8'd0);
                        n_grp.n = n_grp.n + 2'd1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            if (num_done) begin
                if (r_phase <= PH_LEN3) begin
                    n_pl    = num_val;
                    n_phase = PH_POS0;
                end else begin
                    n_spos  = num_val;
                    n_phase = PH_PIC;
                end
            end

            // whole frame or frame in packet: stands apart from slice frame state
            if (do_direct) begin
                n_grp.rec[n_grp.n] = mk_rec(K_RESTART, 8'd1, dlen, 8'd0);
                n_grp.n = n_grp.n + 2'd1;
                n_grp.rec[n_grp.n] = mk_rec(K_ENTRY, 8'd0, 30'd0, 8'd0);
                n_grp.n = n_grp.n + 2'd1;
                n_accum = '0;
                n_pl    = dlen;
                if (dlen == 30'd0) begin
                    n_grp.rec[n_grp.n] = mk_rec(K_DONE, 8'd1, 30'd0, 8'd0);
                    n_grp.n = n_grp.n + 2'd1;
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_FRAME;
                end
            end

            if (do_slice) begin
                if (r_seq[6:0] == 7'd1 || r_pic != r_in_byte || !r_fopen) begin
                    n_cap   = {1'b0, r_low, 1'b1};
                    n_fl    = r_pl;
                    n_wo    = '0;
                    n_ss    = '0;
                    n_pic   = r_in_byte;
                    n_fopen = 1'b1;
                    n_grp.rec[n_grp.n] = mk_rec(K_RESTART, n_cap, n_fl, 8'd0);
                    n_grp.n = n_grp.n + 2'd1;
                end
                slen = n_bl;
                if (r_type == PT_LAST_SLICE && r_spos < {14'd0, slen}) slen = r_spos[15:0];
                n_phase = PH_IDLE;
                wsum    = {1'b0, n_wo} + {15'd0, slen};
                if (n_ss >= n_cap) begin
                    n_grp.rec[n_grp.n] = mk_rec(K_ERROR, 8'd0, 30'd0, 8'd0);
                    n_grp.n = n_grp.n + 2'd1;
                end else begin
                    n_ss = n_ss + 8'd1;
                    n_grp.rec[n_grp.n] = mk_rec(K_ENTRY, n_ss - 8'd1, n_wo, 8'd0);
                    n_grp.n = n_grp.n + 2'd1;
                    if (wsum > {1'b0, n_fl}) begin
                        n_grp.rec[n_grp.n] = mk_rec(K_ERROR, 8'd0, 30'd0, 8'd0);
                        n_grp.n = n_grp.n + 2'd1;
                    end else begin
                        n_pl = {14'd0, slen};
                        if (slen == 16'd0) begin
                            if (r_type == PT_LAST_SLICE || n_wo == n_fl) begin
                                n_grp.rec[n_grp.n] = mk_rec(K_DONE, n_ss, n_wo, 8'd0);
                                n_grp.n = n_grp.n + 2'd1;
                            end
                        end else begin
                            n_phase = PH_SLICE;
                        end
                    end
                end
            end

            // packet ran out before its header or direct frame data was complete (slice data ends quietly)
            if (ended) begin
                if (n_phase != PH_IDLE && n_phase != PH_SLICE) begin
                    n_grp.rec[n_grp.n] = mk_rec(K_ERROR, 8'd0, 30'd0, 8'd0);
                    n_grp.n = n_grp.n + 2'd1;
                end
                n_phase = PH_IDLE;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (!o_stall) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_byte  <= i_data_byte;
            r_in_first <= i_first_of_packet;
            r_in_plen  <= i_packet_length;
        end
    end

    // parse and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_type  <= PT_SLICE;
            r_low   <= '0;
            r_seq   <= '0;
            r_accum <= '0;
            r_fl    <= '0;
            r_spos  <= '0;
            r_pic   <= '0;
            r_fopen <= 1'b0;
            r_cap   <= '0;
            r_ss    <= '0;
            r_wo    <= '0;
            r_bl    <= '0;
            r_pl    <= '0;
        end else if (adv) begin
            r_phase <= n_phase;
            r_type  <= n_type;
            r_low   <= n_low;
            r_seq   <= n_seq;
            r_accum <= n_accum;
            r_fl    <= n_fl;
            r_spos  <= n_spos;
            r_pic   <= n_pic;
            r_fopen <= n_fopen;
            r_cap   <= n_cap;
            r_ss    <= n_ss;
            r_wo    <= n_wo;
            r_bl    <= n_bl;
            r_pl    <= n_pl;
        end
    end

    // record-group queue
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= n_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_sub <= '0;
        end else begin
            if (push) r_wp <= r_wp + PTR_W'(1);
            if (pop) begin
                r_rp  <= r_rp + PTR_W'(1);
                r_sub <= '0;
            end else if (take) begin
                r_sub <= r_sub + 2'd1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(GRP_DEPTH))
        else $error("record queue count beyond depth");

    a_sub_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_sub < head.n))
        else $error("record index beyond head group");

    a_frame_stays_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fopen |=> r_fopen)
        else $error("open frame closed");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CNT_W'(GRP_DEPTH) && !pop) |=> (r_cnt == CNT_W'(GRP_DEPTH) || $past(pop)))
        else $error("queue written while full");

endmodule
